// ===== hw/rtl/kdbq_pkg.sv =====
// kdbq_pkg: shared types and constants for the key debounce / long press event queue
// no dependencies; imported by key_debounce_longpress_event_queue_core and tb_top
`default_nettype none

package kdbq_pkg;

    localparam int KEY_COUNT  = 4;
    localparam int KEY_AW     = 2;
    localparam int RING_SLOTS = 4;
    localparam int RING_AW    = 2;

    typedef logic [3:0] t_code;

    localparam t_code CODE_NONE  = 4'd0;
    localparam t_code SHORT_BASE = 4'd1;
    localparam t_code LONG_BASE  = 4'd5;
    localparam t_code CODE_MAX   = 4'd8;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_DEBOUNCE = 2'd0;
    localparam t_cfg_idx CFG_LONG     = 2'd1;
    localparam t_cfg_idx CFG_REPEAT   = 2'd2;

    localparam logic [7:0] DEBOUNCE_RST = 8'd1;
    localparam logic [9:0] LONG_RST     = 10'd30;
    localparam logic [7:0] REPEAT_RST   = 8'd10;

    localparam logic [3:0] DIV_LAST = 4'd15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_DIV,
        ST_TAKE,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/key_debounce_longpress_event_queue_core.sv =====
// key_debounce_longpress_event_queue_core: four-key debounce, long press / auto repeat
// and a three-entry event queue; depends on kdbq_pkg
`default_nettype none

// Each input beat is either a scan tick (action 0) carrying the raw key levels or a take
// (action 1) that pops the next queued event; every beat yields exactly one result beat.
// A small sequencer visits the keys one per cycle, pausing at each held key in its
// auto-repeat phase while the shared restoring remainder unit checks the repeat interval
// one bit per cycle, and stops at the first published event. A take pops queued entries,
// skipping discarded ones, until it finds one to return or the ring is empty. Input ready
// is high only while the sequencer is idle; a finished result sits in the output register,
// so the next beat is taken while it waits.
// Configuration writes are always ready and must only be issued while the block is idle.
module key_debounce_longpress_event_queue_core (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  wire                    i_action,
    input  wire  [3:0]             i_raw_keys,
    output logic                   o_valid,
    input  wire                    i_ready,
    output logic [3:0]             o_event_code,
    output logic [3:0]             o_last_published,
    output logic [1:0]             o_queued_count,
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  kdbq_pkg::t_cfg_idx i_cfg_index,
    input  wire  [9:0]             i_cfg_data
);
    import kdbq_pkg::*;

    t_state r_state, n_state;

    logic [KEY_AW-1:0]  r_key, n_key;
    logic [3:0]         r_raw, n_raw;
    logic [KEY_COUNT-1:0] r_stable, n_stable;
    logic [KEY_COUNT-1:0] r_long, n_long;
    logic [KEY_COUNT-1:0] r_kq, n_kq;
    logic [KEY_COUNT-1:0] r_disc, n_disc;
    logic [7:0]         r_dcnt [KEY_COUNT];
    logic [7:0]         n_dcnt [KEY_COUNT];
    logic [15:0]        r_held [KEY_COUNT];
    logic [15:0]        n_held [KEY_COUNT];
    t_code              r_ring [RING_SLOTS];
    t_code              n_ring [RING_SLOTS];
    logic [RING_AW-1:0] r_head, n_head;
    logic [RING_AW-1:0] r_tail, n_tail;
    t_code              r_last, n_last;
    t_code              r_code, n_code;

    logic [7:0]         r_dcfg;
    logic [9:0]         r_lcfg;
    logic [7:0]         r_rcfg;

    // shared remainder unit
    logic [15:0]        r_num, n_num;
    logic [7:0]         r_rem, n_rem;
    logic [3:0]         r_dcyc, n_dcyc;

    logic               r_out_valid, n_out_valid;
    t_code              r_out_code, n_out_code;
    t_code              r_out_last, n_out_last;
    logic [1:0]         r_out_cnt, n_out_cnt;

    logic [RING_AW-1:0] w_tail_next;
    logic [RING_AW-1:0] w_head_next;
    logic               w_full;
    logic [RING_AW-1:0] w_occ;

    function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] p);
        ring_next = (p == RING_AW'(RING_SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [KEY_AW-1:0] key_of(input t_code c);
        t_code d;
        d = (c >= LONG_BASE) ? (c - LONG_BASE) : (c - SHORT_BASE);
        key_of = d[KEY_AW-1:0];
    endfunction

    assign w_tail_next = ring_next(r_tail);
    assign w_head_next = ring_next(r_head);
    assign w_full      = (w_tail_next == r_head);
    assign w_occ       = (r_tail >= r_head) ? (r_tail - r_head)
                                            : RING_AW'(r_tail + RING_AW'(RING_SLOTS) - r_head);

    assign o_ready          = (r_state == ST_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_valid          = r_out_valid;
    assign o_event_code     = r_out_code;
    assign o_last_published = r_out_last;
    assign o_queued_count   = r_out_cnt;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcfg <= DEBOUNCE_RST;
            r_lcfg <= LONG_RST;
            r_rcfg <= REPEAT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE: r_dcfg <= i_cfg_data[7:0];
                CFG_LONG:     r_lcfg <= i_cfg_data;
                CFG_REPEAT:   r_rcfg <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_key       <= '0;
            r_stable    <= '0;
            r_long      <= '0;
            r_kq        <= '0;
            r_disc      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_last      <= CODE_NONE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < KEY_COUNT; i++) begin
                r_dcnt[i] <= '0;
                r_held[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_key       <= n_key;
            r_stable    <= n_stable;
            r_long      <= n_long;
            r_kq        <= n_kq;
            r_disc      <= n_disc;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            r_dcnt      <= n_dcnt;
            r_held      <= n_held;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_raw      <= n_raw;
        r_ring     <= n_ring;
        r_code     <= n_code;
        r_num      <= n_num;
        r_rem      <= n_rem;
        r_dcyc     <= n_dcyc;
        r_out_code <= n_out_code;
        r_out_last <= n_out_last;
        r_out_cnt  <= n_out_cnt;
    end

    always_comb begin
        logic        lvl;
        logic        stb;
        logic        lng;
        logic        pub;
        logic        go_div;
        logic [7:0]  dc;
        logic [15:0] hd;
        logic [15:0] h;
        logic [8:0]  rem9;
        t_code       scode;
        t_code       lcode;
        t_code       tcode;
        logic [KEY_AW-1:0] tkey;

        n_state     = r_state;
        n_key       = r_key;
        n_raw       = r_raw;
        n_stable    = r_stable;
        n_long      = r_long;
        n_kq        = r_kq;
        n_disc      = r_disc;
        n_dcnt      = r_dcnt;
        n_held      = r_held;
        n_ring      = r_ring;
        n_head      = r_head;
        n_tail      = r_tail;
        n_last      = r_last;
        n_code      = r_code;
        n_num       = r_num;
        n_rem       = r_rem;
        n_dcyc      = r_dcyc;
        n_out_valid = r_out_valid && !i_ready;
        n_out_code  = r_out_code;
        n_out_last  = r_out_last;
        n_out_cnt   = r_out_cnt;

        lvl    = r_raw[r_key];
        stb    = r_stable[r_key];
        lng    = r_long[r_key];
        pub    = 1'b0;
        go_div = 1'b0;
        dc     = r_dcnt[r_key];
        hd     = r_held[r_key];
        h      = '0;
        rem9   = {r_rem, r_num[15]};
        scode  = SHORT_BASE + t_code'(r_key);
        lcode  = LONG_BASE + t_code'(r_key);
        tcode  = r_ring[r_head];
        tkey   = key_of(tcode);

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_raw   = i_raw_keys;
                    n_key   = '0;
                    n_state = i_action ? ST_TAKE : ST_KEY;
                end
            end

            ST_KEY: begin
                if (lvl != stb) begin
                    dc = dc + 8'd1;
                    if (dc >= r_dcfg) begin
                        dc = '0;
                        hd = '0;
                        if (lvl) begin
                            stb = 1'b1;
                            lng = 1'b0;
                            if (!r_kq[r_key] && !w_full) begin
                                pub                = 1'b1;
                                n_ring[r_tail]     = scode;
                                n_tail             = w_tail_next;
                                n_kq[r_key]        = 1'b1;
                                n_last             = scode;
                                n_code             = scode;
                            end
                        end else begin
                            stb = 1'b0;
                            if (lng) begin
                                n_disc[r_key] = 1'b1;
                            end
                            lng = 1'b0;
                        end
                    end
                end else begin
                    dc = '0;
                end

                if (!pub && stb) begin
                    h  = hd + 16'd1;
                    hd = h;
                    if (!lng) begin
                        // a refused short publish leaves the ring untouched, so this sees it as is
                        if (h >= 16'(r_lcfg) && !r_kq[r_key]) begin
                            n_disc[r_key] = 1'b0;
                            if (!w_full) begin
                                pub            = 1'b1;
                                lng            = 1'b1;
                                n_ring[r_tail] = lcode;
                                n_tail         = w_tail_next;
                                n_kq[r_key]    = 1'b1;
                                n_last         = lcode;
                                n_code         = lcode;
                            end
                        end
                    end else if (h > 16'(r_lcfg) && r_rcfg != 8'd0) begin
                        go_div = 1'b1;
                        n_num  = h - 16'(r_lcfg);
                        n_rem  = '0;
                        n_dcyc = '0;
                    end
                end

                n_dcnt[r_key]   = dc;
                n_held[r_key]   = hd;
                n_stable[r_key] = stb;
                n_long[r_key]   = lng;

                if (pub) begin
                    n_state = ST_DONE;
                end else if (go_div) begin
                    n_state = ST_DIV;
                end else if (r_key == KEY_AW'(KEY_COUNT - 1)) begin
                    n_code  = CODE_NONE;
                    n_state = ST_DONE;
                end else begin
                    n_key = r_key + 1'b1;
                end
            end

            ST_DIV: begin
                // restoring remainder, one dividend bit per cycle
                if (rem9 >= {1'b0, r_rcfg}) begin
                    rem9 = rem9 - {1'b0, r_rcfg};
                end
                n_rem  = rem9[7:0];
                n_num  = {r_num[14:0], 1'b0};
                n_dcyc = r_dcyc + 4'd1;
                if (r_dcyc == DIV_LAST) begin
                    if (rem9[7:0] == 8'd0 && !r_kq[r_key]) begin
                        n_disc[r_key] = 1'b0;
                        if (!w_full) begin
                            pub            = 1'b1;
                            n_ring[r_tail] = lcode;
                            n_tail         = w_tail_next;
                            n_kq[r_key]    = 1'b1;
                            n_last         = lcode;
                            n_code         = lcode;
                        end
                    end
                    if (pub) begin
                        n_state = ST_DONE;
                    end else if (r_key == KEY_AW'(KEY_COUNT - 1)) begin
                        n_code  = CODE_NONE;
                        n_state = ST_DONE;
                    end else begin
                        n_key   = r_key + 1'b1;
                        n_state = ST_KEY;
                    end
                end
            end

            ST_TAKE: begin
                if (r_head == r_tail) begin
                    n_code  = CODE_NONE;
                    n_state = ST_DONE;
                end else begin
                    n_head     = w_head_next;
                    n_kq[tkey] = 1'b0;
                    if (tcode >= LONG_BASE && r_disc[tkey]) begin
                        // discarded long event, drop and keep looking
                        n_disc[tkey] = 1'b0;
                    end else begin
                        n_code  = tcode;
                        n_state = ST_DONE;
                    end
                end
            end

            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_code  = r_code;
                    n_out_last  = r_last;
                    n_out_cnt   = 2'(w_occ);
                    n_state     = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // one queued entry per key, so the queued-key mask tracks ring occupancy
    a_kq_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_kq) == int'(w_occ))
        else $error("queued key mask disagrees with ring occupancy");

    a_long_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_long & ~r_stable) == '0)
        else $error("long press active on a released key");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_rcfg))
        else $error("remainder unit out of range");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (r_code <= CODE_MAX))
        else $error("bad result code");

    a_ring_not_full_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TAKE && r_head != r_tail) |=> (r_state == ST_TAKE || r_state == ST_DONE))
        else $error("take sequence left early");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for key_debounce_longpress_event_queue_core, with its own
// model of the debounce, long press, repeat and event ring logic; depends on kdbq_pkg
`default_nettype none

module tb_top;

    import kdbq_pkg::*;

    localparam logic ACT_SCAN = 1'b0;
    localparam logic ACT_TAKE = 1'b1;

    localparam int RUN_LIMIT       = 2_000_000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 100;

    typedef struct packed {
        t_code      code;
        t_code      last;
        logic [1:0] depth;
    } key_result_t;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       i_action    = ACT_SCAN;
    logic [3:0] i_raw_keys  = 4'd0;
    logic       i_ready     = 1'b0;
    logic       i_cfg_valid = 1'b0;
    t_cfg_idx   i_cfg_index = CFG_DEBOUNCE;
    logic [9:0] i_cfg_data  = 10'd0;
    logic       o_ready;
    logic       o_valid;
    logic [3:0] o_event_code;
    logic [3:0] o_last_published;
    logic [1:0] o_queued_count;
    logic       o_cfg_ready;

    key_debounce_longpress_event_queue_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_raw_keys      (i_raw_keys),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_event_code    (o_event_code),
        .o_last_published(o_last_published),
        .o_queued_count  (o_queued_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // keypad model state
    logic [7:0]  cfg_debounce;
    logic [9:0]  cfg_long;
    logic [7:0]  cfg_repeat;
    logic [3:0]  stable_keys;
    logic [7:0]  debounce_run [KEY_COUNT];
    logic [15:0] hold_ticks [KEY_COUNT];
    logic [3:0]  long_keys;
    t_code       ring_code [RING_SLOTS];
    logic [1:0]  rd_slot;
    logic [1:0]  wr_slot;
    logic [3:0]  keys_in_ring;
    logic [3:0]  discard_keys;
    t_code       last_code;

    key_result_t keypad_outcomes [$];

    logic [3:0] held_keys = 4'd0;
    int burst_left     = 0;
    int tx_gap_max     = 0;
    int rx_stall_pct   = 0;
    int hold_asked     = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int rx_run         = 0;
    int cycle_count    = 0;
    int mismatch_count = 0;
    int scan_beats     = 0;
    int take_beats     = 0;
    int events_seen    = 0;
    int settings_used  = 0;

    function automatic void reset_keypad();
        cfg_debounce = DEBOUNCE_RST;
        cfg_long     = LONG_RST;
        cfg_repeat   = REPEAT_RST;
        stable_keys  = 4'd0;
        long_keys    = 4'd0;
        for (int i = 0; i < KEY_COUNT; i++) begin
            debounce_run[i] = 8'd0;
            hold_ticks[i]   = 16'd0;
        end
        for (int s = 0; s < RING_SLOTS; s++)
            ring_code[s] = CODE_NONE;
        rd_slot      = 2'd0;
        wr_slot      = 2'd0;
        keys_in_ring = 4'd0;
        discard_keys = 4'd0;
        last_code    = CODE_NONE;
    endfunction

    function automatic logic [3:0] key_mask_of(input t_code c);
        t_code k;
        k = (c >= LONG_BASE) ? c - LONG_BASE : c - SHORT_BASE;
        return 4'b0001 << k[1:0];
    endfunction

    function automatic logic try_publish(input t_code c);
        logic [3:0] kb;
        kb = key_mask_of(c);
        if ((keys_in_ring & kb) != 4'd0)
            return 1'b0;
        // a long event clears the discard mark even when the ring then refuses it
        if (c >= LONG_BASE)
            discard_keys = discard_keys & ~kb;
        if (wr_slot + 2'd1 == rd_slot)
            return 1'b0;
        ring_code[wr_slot] = c;
        wr_slot      = wr_slot + 2'd1;
        keys_in_ring = keys_in_ring | kb;
        last_code    = c;
        return 1'b1;
    endfunction

    function automatic t_code scan_keys(input logic [3:0] raw);
        logic [15:0] h;
        t_code sc;
        t_code lc;
        for (int i = 0; i < KEY_COUNT; i++) begin
            sc = SHORT_BASE + i[3:0];
            lc = LONG_BASE + i[3:0];
            if (raw[i] != stable_keys[i]) begin
                debounce_run[i] = debounce_run[i] + 8'd1;
                if (debounce_run[i] >= cfg_debounce) begin
                    debounce_run[i] = 8'd0;
                    hold_ticks[i]   = 16'd0;
                    if (raw[i]) begin
                        stable_keys[i] = 1'b1;
                        long_keys[i]   = 1'b0;
                        if (try_publish(sc))
                            return sc;
                    end else begin
                        stable_keys[i] = 1'b0;
                        if (long_keys[i])
                            discard_keys[i] = 1'b1;
                        long_keys[i] = 1'b0;
                    end
                end
            end else begin
                debounce_run[i] = 8'd0;
            end

            if (stable_keys[i]) begin
                h = hold_ticks[i] + 16'd1;
                hold_ticks[i] = h;
                if (!long_keys[i]) begin
                    if (h >= {6'd0, cfg_long}) begin
                        if (try_publish(lc)) begin
                            long_keys[i] = 1'b1;
                            return lc;
                        end
                    end
                end else if (h > {6'd0, cfg_long} && cfg_repeat != 8'd0) begin
                    if ((h - {6'd0, cfg_long}) % {8'd0, cfg_repeat} == 16'd0) begin
                        if (try_publish(lc))
                            return lc;
                    end
                end
            end
        end
        return CODE_NONE;
    endfunction

    function automatic t_code pop_event();
        t_code c;
        logic [3:0] kb;
        while (rd_slot != wr_slot) begin
            c  = ring_code[rd_slot];
            kb = key_mask_of(c);
            rd_slot      = rd_slot + 2'd1;
            keys_in_ring = keys_in_ring & ~kb;
            // long events of released keys are dropped silently
            if (c >= LONG_BASE && (discard_keys & kb) != 4'd0) begin
                discard_keys = discard_keys & ~kb;
                continue;
            end
            return c;
        end
        return CODE_NONE;
    endfunction

    function automatic key_result_t step_keypad(input logic act, input logic [3:0] raw);
        key_result_t r;
        r.code  = (act == ACT_TAKE) ? pop_event() : scan_keys(raw);
        r.last  = last_code;
        r.depth = wr_slot - rd_slot;
        return r;
    endfunction

    // result side: runs of ready or stall, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_OFF_CYCLES;
            i_ready     <= 1'b0;
        end else if (rx_run != 0) begin
            rx_run <= rx_run - 1;
        end else begin
            rx_run  <= $urandom_range(0, 7);
            i_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            key_result_t want;
            if (keypad_outcomes.size() == 0) begin
                $display("%0t: result beat with nothing pending: code %0d last %0d count %0d",
                         $time, o_event_code, o_last_published, o_queued_count);
                mismatch_count++;
            end else begin
                want = keypad_outcomes.pop_front();
                if (want.code !== o_event_code || want.last !== o_last_published ||
                    want.depth !== o_queued_count) begin
                    $display("%0t: expected code %0d last %0d count %0d, got %0d %0d %0d",
                             $time, want.code, want.last, want.depth,
                             o_event_code, o_last_published, o_queued_count);
                    mismatch_count++;
                end
            end
            if (o_event_code != CODE_NONE)
                events_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_beat(input logic act, input logic [3:0] keys);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, tx_gap_max);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid    <= 1'b1;
        i_action   <= act;
        i_raw_keys <= keys;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        keypad_outcomes.push_back(step_keypad(act, keys));
        if (act == ACT_TAKE)
            take_beats++;
        else
            scan_beats++;
    endtask

    task automatic wait_drained();
        i_valid   <= 1'b0;
        burst_left = 0;
        while (keypad_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_beat(input t_cfg_idx idx, input logic [9:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [7:0] db, input logic [9:0] lp,
                                  input logic [7:0] rp);
        wait_drained();
        cfg_beat(CFG_DEBOUNCE, {2'b00, db});
        cfg_beat(CFG_LONG, lp);
        cfg_beat(CFG_REPEAT, {2'b00, rp});
        i_cfg_valid <= 1'b0;
        cfg_debounce = db;
        cfg_long     = lp;
        cfg_repeat   = rp;
        settings_used++;
    endtask

    // held_keys drifts slowly; bounce flips one key for a single tick
    task automatic run_scan_mix(input int beats, input int take_pct, input int flip_pm,
                                input int bounce_pct, input int noise_pct);
        logic [3:0] raw;
        for (int n = 0; n < beats; n++) begin
            if ($urandom_range(0, 99) < take_pct) begin
                raw = 4'($urandom_range(0, 15));
                send_beat(ACT_TAKE, raw);
            end else begin
                for (int k = 0; k < KEY_COUNT; k++)
                    if ($urandom_range(0, 999) < flip_pm)
                        held_keys[k] = ~held_keys[k];
                raw = held_keys;
                if ($urandom_range(0, 99) < bounce_pct)
                    raw[2'($urandom_range(0, 3))] ^= 1'b1;
                if ($urandom_range(0, 99) < noise_pct)
                    raw = 4'($urandom_range(0, 15));
                send_beat(ACT_SCAN, raw);
            end
        end
    endtask

    task automatic test_directed_basics();
        tx_gap_max   = 2;
        rx_stall_pct = 20;
        // reset settings: empty take, shorts filling the ring, refusal when full
        send_beat(ACT_TAKE, 4'b1111);
        send_beat(ACT_SCAN, 4'b0000);
        repeat (4) send_beat(ACT_SCAN, 4'b1111);
        send_beat(ACT_TAKE, 4'b0000);
        send_beat(ACT_SCAN, 4'b1111);
        repeat (4) send_beat(ACT_TAKE, 4'b0000);
        // short timers: long press, repeat refused while queued, discard on release
        apply_settings(8'd1, 10'd2, 8'd1);
        repeat (3) send_beat(ACT_SCAN, 4'b0001);
        send_beat(ACT_TAKE, 4'b0000);
        send_beat(ACT_SCAN, 4'b0001);
        send_beat(ACT_SCAN, 4'b0000);
        send_beat(ACT_TAKE, 4'b0000);
        repeat (3) send_beat(ACT_SCAN, 4'b1111);
        repeat (3) send_beat(ACT_TAKE, 4'b0000);
    endtask

    task automatic test_default_timing();
        apply_settings(DEBOUNCE_RST, LONG_RST, REPEAT_RST);
        tx_gap_max   = 4;
        rx_stall_pct = 30;
        run_scan_mix(350, 20, 15, 5, 3);
    endtask

    task automatic test_fast_repeat();
        apply_settings(8'd1, 10'd1, 8'd1);
        tx_gap_max   = 0;
        rx_stall_pct = 0;
        run_scan_mix(300, 30, 100, 5, 5);
    endtask

    task automatic test_bounce_filter();
        apply_settings(8'd3, 10'd6, 8'd2);
        tx_gap_max   = 8;
        rx_stall_pct = 50;
        run_scan_mix(300, 25, 40, 30, 5);
    endtask

    task automatic test_slowest_settings();
        apply_settings(8'd255, 10'd1023, 8'd255);
        tx_gap_max   = 2;
        rx_stall_pct = 20;
        held_keys    = ~held_keys;
        run_scan_mix(380, 15, 1, 0, 0);
    endtask

    task automatic test_full_queue_stall();
        apply_settings(8'd2, 10'd4, 8'd3);
        tx_gap_max   = 0;
        rx_stall_pct = 10;
        hold_asked <= hold_asked + 1;
        run_scan_mix(60, 20, 40, 0, 0);
    endtask

    task automatic test_drain_pause();
        apply_settings(8'd1, 10'd5, 8'd2);
        tx_gap_max   = 3;
        rx_stall_pct = 30;
        for (int c = 0; c < 3; c++) begin
            run_scan_mix(30, 25, 50, 5, 5);
            wait_drained();
        end
    endtask

    task automatic test_random_settings();
        for (int c = 0; c < 4; c++) begin
            apply_settings(8'($urandom_range(1, 6)), 10'($urandom_range(1, 40)),
                           8'($urandom_range(1, 12)));
            tx_gap_max   = $urandom_range(0, 6);
            rx_stall_pct = $urandom_range(0, 60);
            run_scan_mix(70, $urandom_range(10, 40), 30, 10, 5);
        end
    endtask

    initial begin
        reset_keypad();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_basics();
        test_default_timing();
        test_fast_repeat();
        test_bounce_filter();
        test_slowest_settings();
        test_full_queue_stall();
        test_drain_pause();
        test_random_settings();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("run covered %0d scan beats and %0d take beats over %0d register settings",
                 scan_beats, take_beats, settings_used);
        $display("%0d result beats carried a nonzero event code", events_seen);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/kdbq_pkg.sv
hw/rtl/key_debounce_longpress_event_queue_core.sv
tb/tb_top.sv
